FILE: hw/rtl/pulse_train_call_detector_core_defines.svh
// Assertion macros shared by the pulse train call detector checker
`ifndef PULSE_TRAIN_CALL_DETECTOR_CORE_DEFINES_SVH
`define PULSE_TRAIN_CALL_DETECTOR_CORE_DEFINES_SVH

// Property checked on every rising clock edge outside reset
`define PTCD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included
`define PTCD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ptcd_pkg.sv
// Package with types, constants and helpers of the pulse train call detector
package ptcd_pkg;

	// Register reset values
	localparam logic [15:0] HIGH_TICKS_RST     = 16'd1000;
	localparam logic [15:0] LOW_TICKS_RST      = 16'd2000;
	localparam logic [15:0] HIGH_EDGES_MIN_RST = 16'd30;
	localparam logic [15:0] HIGH_EDGES_MAX_RST = 16'd45;
	localparam logic [15:0] LOW_EDGES_MAX_RST  = 16'd10;
	localparam logic [3:0]  CLICKS_MIN_RST     = 4'd4;
	localparam logic [3:0]  CLICKS_MAX_RST     = 4'd9;
	localparam logic [15:0] NOISE_EDGES_RST    = 16'd3;

	// Saturation limits
	localparam logic [15:0] CNT_MAX   = 16'hFFFF;
	localparam logic [4:0]  CLICK_SAT = 5'd31;

	// Reciprocal of five for a 16-bit dividend: floor(x * 52429 / 2^18) == x / 5
	localparam logic [33:0] DIV5_MUL   = 34'd52429;
	localparam int          DIV5_SHIFT = 18;

	// Register map, word index
	typedef enum logic [2:0] {
		REG_HIGH_TICKS     = 3'd0,
		REG_LOW_TICKS      = 3'd1,
		REG_HIGH_EDGES_MIN = 3'd2,
		REG_HIGH_EDGES_MAX = 3'd3,
		REG_LOW_EDGES_MAX  = 3'd4,
		REG_CLICKS_MIN     = 3'd5,
		REG_CLICKS_MAX     = 3'd6,
		REG_NOISE_EDGES    = 3'd7
	} ptcd_reg_t;

	// Run phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_HIGH = 3'b010,
		PH_LOW  = 3'b100
	} ptcd_phase_t;

	// Phase codes as shown on the result beat
	localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
	localparam logic [1:0] PHASE_CODE_HIGH = 2'd1;
	localparam logic [1:0] PHASE_CODE_LOW  = 2'd2;

	// Configuration seen by the detector
	typedef struct packed {
		logic [15:0] high_ticks;
		logic [15:0] low_ticks;
		logic [15:0] high_edges_min;
		logic [15:0] high_edges_max;
		logic [15:0] low_edges_max;
		logic [3:0]  clicks_min;
		logic [3:0]  clicks_max;
		logic [15:0] noise_edges_min;
		logic [15:0] noise_ticks;     // tick of the early check
	} ptcd_cfg_t;

	// One result beat
	typedef struct packed {
		logic [31:0] calls_total;
		logic        call_found;
		logic [1:0]  phase;
		logic        active;
	} ptcd_result_t;

	localparam int RESULT_W = $bits(ptcd_result_t);
	localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

	// Tick of the early check: a fifth of the click window, at least one
	function automatic logic [15:0] noise_tick(input logic [15:0] win);
		logic [33:0] prod;
		logic [15:0] quo;
		prod = {18'd0, win} * DIV5_MUL;
		quo  = prod[DIV5_SHIFT +: 16];
		return (quo == 16'd0) ? 16'd1 : quo;
	endfunction

	// Output code of a phase
	function automatic logic [1:0] phase_code(input ptcd_phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_HIGH: code = PHASE_CODE_HIGH;
			PH_LOW:  code = PHASE_CODE_LOW;
			default: code = PHASE_CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

FILE: hw/rtl/ptcd_cfg_regs.sv
// Configuration register file with its APB-style access port
module ptcd_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output ptcd_pkg::ptcd_cfg_t cfg
);

	logic                wr_en;
	ptcd_pkg::ptcd_reg_t reg_idx;
	ptcd_pkg::ptcd_cfg_t cfg_q;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = ptcd_pkg::ptcd_reg_t'(paddr[4:2]);
	assign cfg     = cfg_q;

	// Register writes; the early-check tick is recomputed with the window length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_ticks      <= ptcd_pkg::HIGH_TICKS_RST;
			cfg_q.low_ticks       <= ptcd_pkg::LOW_TICKS_RST;
			cfg_q.high_edges_min  <= ptcd_pkg::HIGH_EDGES_MIN_RST;
			cfg_q.high_edges_max  <= ptcd_pkg::HIGH_EDGES_MAX_RST;
			cfg_q.low_edges_max   <= ptcd_pkg::LOW_EDGES_MAX_RST;
			cfg_q.clicks_min      <= ptcd_pkg::CLICKS_MIN_RST;
			cfg_q.clicks_max      <= ptcd_pkg::CLICKS_MAX_RST;
			cfg_q.noise_edges_min <= ptcd_pkg::NOISE_EDGES_RST;
			cfg_q.noise_ticks     <= ptcd_pkg::noise_tick(ptcd_pkg::HIGH_TICKS_RST);
		end else if (wr_en) begin
			case (reg_idx)
				ptcd_pkg::REG_HIGH_TICKS: begin
					cfg_q.high_ticks  <= pwdata[15:0];
					cfg_q.noise_ticks <= ptcd_pkg::noise_tick(pwdata[15:0]);
				end
				ptcd_pkg::REG_LOW_TICKS:      cfg_q.low_ticks       <= pwdata[15:0];
				ptcd_pkg::REG_HIGH_EDGES_MIN: cfg_q.high_edges_min  <= pwdata[15:0];
				ptcd_pkg::REG_HIGH_EDGES_MAX: cfg_q.high_edges_max  <= pwdata[15:0];
				ptcd_pkg::REG_LOW_EDGES_MAX:  cfg_q.low_edges_max   <= pwdata[15:0];
				ptcd_pkg::REG_CLICKS_MIN:     cfg_q.clicks_min      <= pwdata[3:0];
				ptcd_pkg::REG_CLICKS_MAX:     cfg_q.clicks_max      <= pwdata[3:0];
				ptcd_pkg::REG_NOISE_EDGES:    cfg_q.noise_edges_min <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			ptcd_pkg::REG_HIGH_TICKS:     prdata = {16'd0, cfg_q.high_ticks};
			ptcd_pkg::REG_LOW_TICKS:      prdata = {16'd0, cfg_q.low_ticks};
			ptcd_pkg::REG_HIGH_EDGES_MIN: prdata = {16'd0, cfg_q.high_edges_min};
			ptcd_pkg::REG_HIGH_EDGES_MAX: prdata = {16'd0, cfg_q.high_edges_max};
			ptcd_pkg::REG_LOW_EDGES_MAX:  prdata = {16'd0, cfg_q.low_edges_max};
			ptcd_pkg::REG_CLICKS_MIN:     prdata = {28'd0, cfg_q.clicks_min};
			ptcd_pkg::REG_CLICKS_MAX:     prdata = {28'd0, cfg_q.clicks_max};
			ptcd_pkg::REG_NOISE_EDGES:    prdata = {16'd0, cfg_q.noise_edges_min};
			default:                      prdata = 32'd0;
		endcase
	end

endmodule

FILE: hw/rtl/ptcd_fsm.sv
// Run state machine and counters, updated once per accepted tick
module ptcd_fsm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic                   edge_seen,
	input  ptcd_pkg::ptcd_cfg_t    cfg,
	output ptcd_pkg::ptcd_result_t result
);

	ptcd_pkg::ptcd_phase_t phase_q, phase_d;
	logic [15:0] ticks_q, ticks_d, ticks_inc;
	logic [15:0] edges_q, edges_d, edges_inc;
	logic [4:0]  clicks_q, clicks_d;
	logic        armed_q, armed_d;
	logic [31:0] total_q, total_d;
	logic        finish, may_record, found;
	logic        high_good;

	// Saturating window counters
	assign ticks_inc = (ticks_q != ptcd_pkg::CNT_MAX) ? ticks_q + 16'd1 : ticks_q;
	assign edges_inc = (edge_seen && edges_q != ptcd_pkg::CNT_MAX) ?
		edges_q + 16'd1 : edges_q;

	assign high_good = (edges_inc >= cfg.high_edges_min) &&
		(edges_inc <= cfg.high_edges_max) && (clicks_q <= {1'b0, cfg.clicks_max});

	// Next state for one tick
	always_comb begin
		phase_d    = phase_q;
		ticks_d    = ticks_q;
		edges_d    = edges_q;
		clicks_d   = clicks_q;
		armed_d    = armed_q;
		total_d    = total_q;
		finish     = 1'b0;
		may_record = 1'b0;
		found      = 1'b0;
		case (phase_q)
			ptcd_pkg::PH_IDLE: begin
				if (edge_seen) begin
					phase_d  = ptcd_pkg::PH_HIGH;
					ticks_d  = 16'd0;
					edges_d  = 16'd0;
					clicks_d = 5'd0;
					armed_d  = 1'b1;
				end
			end
			ptcd_pkg::PH_HIGH: begin
				ticks_d = ticks_inc;
				edges_d = edges_inc;
				// early noise check, once per run
				if (armed_q && ticks_inc >= cfg.noise_ticks) begin
					armed_d = 1'b0;
					if (edges_inc < cfg.noise_edges_min)
						finish = 1'b1;
				end
				if (!finish && ticks_inc >= cfg.high_ticks) begin
					if (high_good) begin
						armed_d = 1'b0;
						phase_d = ptcd_pkg::PH_LOW;
						ticks_d = 16'd0;
						edges_d = 16'd0;
					end else begin
						finish     = 1'b1;
						may_record = 1'b1;
					end
				end
			end
			ptcd_pkg::PH_LOW: begin
				ticks_d = ticks_inc;
				edges_d = edges_inc;
				if (ticks_inc >= cfg.low_ticks) begin
					if (edges_inc <= cfg.low_edges_max) begin
						if (clicks_q != ptcd_pkg::CLICK_SAT)
							clicks_d = clicks_q + 5'd1;
						phase_d = ptcd_pkg::PH_HIGH;
						ticks_d = 16'd0;
						edges_d = 16'd0;
					end else begin
						finish     = 1'b1;
						may_record = 1'b1;
					end
				end
			end
			default: phase_d = ptcd_pkg::PH_IDLE;
		endcase
		// end of run, call recorded when allowed and enough clicks
		if (finish) begin
			if (may_record && clicks_q >= {1'b0, cfg.clicks_min}) begin
				total_d = total_q + 32'd1;
				found   = 1'b1;
			end
			phase_d  = ptcd_pkg::PH_IDLE;
			ticks_d  = 16'd0;
			edges_d  = 16'd0;
			clicks_d = 5'd0;
			armed_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ptcd_pkg::PH_IDLE;
			ticks_q  <= 16'd0;
			edges_q  <= 16'd0;
			clicks_q <= 5'd0;
			armed_q  <= 1'b0;
			total_q  <= 32'd0;
		end else if (fire) begin
			phase_q  <= phase_d;
			ticks_q  <= ticks_d;
			edges_q  <= edges_d;
			clicks_q <= clicks_d;
			armed_q  <= armed_d;
			total_q  <= total_d;
		end
	end

	assign result.active      = (phase_d != ptcd_pkg::PH_IDLE);
	assign result.phase       = ptcd_pkg::phase_code(phase_d);
	assign result.call_found  = found;
	assign result.calls_total = total_d;

endmodule

FILE: hw/rtl/ptcd_out_reg.sv
// Result register between the detector and the output stream
module ptcd_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  ptcd_pkg::ptcd_result_t          result,
	output logic                            load_ok,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ptcd_pkg::M_DATA_W-1:0]   m_tdata
);

	logic                   valid_q;
	ptcd_pkg::ptcd_result_t data_q;

	// Free to load when empty or when the held beat leaves this cycle
	assign load_ok = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load_ok)
			valid_q <= fire;
	end

	always_ff @(posedge clk) begin
		if (fire)
			data_q <= result;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(ptcd_pkg::M_DATA_W - ptcd_pkg::RESULT_W){1'b0}}, data_q};

endmodule

FILE: hw/rtl/pulse_train_call_detector_core.sv
// Pulse train call detector: the result beat is registered and shows in the cycle after its input beat.
// Throughput one tick per cycle; the result register frees up as its beat leaves,
// so s_tready stays high while m_tready is high.
// arst_n clears the run state, the call count and the output valid, and loads
// the register reset values; no clearing pass is needed.
// Top level: APB-style configuration, tick stream in, status stream out.
module pulse_train_call_detector_core (
	input  logic        clk,
	input  logic        arst_n,
	// tick stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] edge_seen, [7:1] zero
	// status stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [0] active, [2:1] phase, [3] call_found,
	                               // [35:4] calls_total, [39:36] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ptcd_pkg::ptcd_cfg_t    cfg;
	ptcd_pkg::ptcd_result_t result;
	logic                   fire;
	logic                   load_ok;

	assign pready   = 1'b1;
	assign s_tready = load_ok;
	assign fire     = s_tvalid & load_ok;

	ptcd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	ptcd_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.edge_seen (s_tdata[0]),
		.cfg       (cfg),
		.result    (result)
	);

	ptcd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.result   (result),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: hw/rtl/ptcd_checker.sv
// Port-level checker for the pulse train call detector, bound to the top level
`include "pulse_train_call_detector_core_defines.svh"

module ptcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// active flag agrees with the phase code
	`PTCD_ASSERT(a_active_phase, m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] != 2'd0)), "active and phase disagree")

	// phase code three is never shown
	`PTCD_ASSERT(a_phase_legal, m_tvalid |-> (m_tdata[2:1] != 2'b11), "illegal phase code")

	// a call is recorded only as a run ends
	`PTCD_ASSERT(a_call_at_end, (m_tvalid && m_tdata[3]) |-> (m_tdata[2:1] == 2'd0), "call outside idle")

	// input side never stalls while the result register is empty
	`PTCD_ASSERT_ALWAYS(a_ready_empty, (!m_tvalid) |-> s_tready, "stall with empty result register")

	// a stalled result beat holds
	`PTCD_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result beat changed under stall")

endmodule

bind pulse_train_call_detector_core ptcd_checker u_ptcd_checker (.*);

FILE: bench/pulse_train_call_detector_core_tb.sv
// Self-checking bench for the pulse train call detector: tick stream in, status beats out
`timescale 1ns / 1ps

module pulse_train_call_detector_core_tb;
	import ptcd_pkg::*;

	localparam int TIMEOUT_NS = 2_000_000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [0] edge_seen, [7:1] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [0] active, [2:1] phase, [3] call_found, [35:4] calls_total
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pulse_train_call_detector_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Detector configuration as the bench believes it to be
	logic [15:0] cfg_hi_ticks, cfg_lo_ticks, cfg_hi_min, cfg_hi_max, cfg_lo_max;
	logic [15:0] cfg_noise_min;
	logic [3:0]  cfg_clk_min, cfg_clk_max;

	// Predicted run state
	logic [1:0]  run_ph;
	logic [15:0] win_ticks, win_edges;
	logic [4:0]  clicks;
	logic        noise_armed;
	logic [31:0] calls_seen;

	// Status beats still to come, oldest first
	ptcd_result_t status_due[$];
	int mismatches;

	// Stimulus shaping
	int   send_gap_pct;
	int   stall_pct;
	int   edge_goal;
	logic noisy_run;

	always #2 clk = ~clk;

	// Receiver back-pressure
	always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

	function automatic void flag_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
	endfunction

	function automatic void apply_reg(input ptcd_reg_t idx, input logic [31:0] val);
		case (idx)
			REG_HIGH_TICKS:     cfg_hi_ticks  = val[15:0];
			REG_LOW_TICKS:      cfg_lo_ticks  = val[15:0];
			REG_HIGH_EDGES_MIN: cfg_hi_min    = val[15:0];
			REG_HIGH_EDGES_MAX: cfg_hi_max    = val[15:0];
			REG_LOW_EDGES_MAX:  cfg_lo_max    = val[15:0];
			REG_CLICKS_MIN:     cfg_clk_min   = val[3:0];
			REG_CLICKS_MAX:     cfg_clk_max   = val[3:0];
			REG_NOISE_EDGES:    cfg_noise_min = val[15:0];
			default: ;
		endcase
	endfunction

	function automatic void set_window(input logic [1:0] ph);
		run_ph    = ph;
		win_ticks = '0;
		win_edges = '0;
	endfunction

	// Ends the run; a call is logged if allowed and enough clicks were seen
	function automatic logic close_run(input logic may_record);
		logic rec;
		rec = may_record && (clicks >= {1'b0, cfg_clk_min});
		if (rec)
			calls_seen = calls_seen + 32'd1;
		set_window(PHASE_CODE_IDLE);
		clicks      = '0;
		noise_armed = 1'b0;
		return rec;
	endfunction

	// One timer tick through the detector; returns the status beat it causes
	function automatic ptcd_result_t detector_tick(input logic edge_in);
		ptcd_result_t r;
		logic        found;
		logic        ended;
		logic [15:0] chk_tick;
		found = 1'b0;
		ended = 1'b0;
		if (run_ph == PHASE_CODE_IDLE) begin
			// starting edge opens a click window but is not counted
			if (edge_in) begin
				set_window(PHASE_CODE_HIGH);
				clicks      = '0;
				noise_armed = 1'b1;
			end
		end else begin
			if (win_ticks != CNT_MAX)
				win_ticks++;
			if (edge_in && win_edges != CNT_MAX)
				win_edges++;
			// early noise check, once per run, ahead of the window-end test
			if (run_ph == PHASE_CODE_HIGH && noise_armed) begin
				chk_tick = cfg_hi_ticks / 16'd5;
				if (chk_tick == '0)
					chk_tick = 16'd1;
				if (win_ticks >= chk_tick) begin
					noise_armed = 1'b0;
					if (win_edges < cfg_noise_min) begin
						found = close_run(1'b0);
						ended = 1'b1;
					end
				end
			end
			if (!ended && run_ph == PHASE_CODE_HIGH && win_ticks >= cfg_hi_ticks) begin
				if (win_edges >= cfg_hi_min && win_edges <= cfg_hi_max &&
						clicks <= {1'b0, cfg_clk_max}) begin
					noise_armed = 1'b0;
					set_window(PHASE_CODE_LOW);
				end else begin
					found = close_run(1'b1);
				end
			end else if (!ended && run_ph == PHASE_CODE_LOW && win_ticks >= cfg_lo_ticks) begin
				if (win_edges <= cfg_lo_max) begin
					if (clicks != CLICK_SAT)
						clicks++;
					set_window(PHASE_CODE_HIGH);
				end else begin
					found = close_run(1'b1);
				end
			end
		end
		r.active      = (run_ph != PHASE_CODE_IDLE);
		r.phase       = run_ph;
		r.call_found  = found;
		r.calls_total = calls_seen;
		return r;
	endfunction

	// Edge count aimed at for a freshly opened window; mostly in bounds
	function automatic void pick_goal();
		int span, lo, hi;
		if (run_ph == PHASE_CODE_HIGH) begin
			span = int'(cfg_hi_ticks);
			lo   = int'(cfg_hi_min);
			hi   = int'((cfg_hi_max < cfg_hi_ticks) ? cfg_hi_max : cfg_hi_ticks);
		end else begin
			span = int'(cfg_lo_ticks);
			lo   = 0;
			hi   = int'((cfg_lo_max < cfg_lo_ticks) ? cfg_lo_max : cfg_lo_ticks);
		end
		if (lo <= hi && $urandom_range(0, 99) < 85)
			edge_goal = int'($urandom_range(lo, hi));
		else
			edge_goal = int'($urandom_range(0, span));
	endfunction

	// Next edge flag: spreads the goal's edges over the rest of the window
	function automatic logic next_edge();
		int left, need;
		if (run_ph == PHASE_CODE_IDLE)
			return ($urandom_range(0, 3) == 0);
		if (noisy_run)
			return 1'($urandom_range(0, 1));
		if (run_ph == PHASE_CODE_HIGH && noise_armed && win_edges < cfg_noise_min &&
				$urandom_range(0, 9) != 0)
			return 1'b1;
		left = ((run_ph == PHASE_CODE_HIGH) ? int'(cfg_hi_ticks) : int'(cfg_lo_ticks)) -
			int'(win_ticks);
		need = edge_goal - int'(win_edges);
		if (need <= 0)
			return 1'b0;
		if (left <= 1 || need >= left)
			return 1'b1;
		return ($urandom_range(1, left) <= need);
	endfunction

	// Sends one tick beat; called and returns at a falling edge
	task automatic send_tick(input logic edge_in);
		logic [1:0] was;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, edge_in};
		do @(posedge clk); while (!s_tready);
		was = run_ph;
		status_due.push_back(detector_tick(edge_in));
		if (was == PHASE_CODE_IDLE && run_ph != PHASE_CODE_IDLE)
			noisy_run = ($urandom_range(0, 9) == 0);
		if (run_ph != PHASE_CODE_IDLE && win_ticks == '0)
			pick_goal();
		@(negedge clk);
	endtask

	// Holds the tick stream until every status beat has arrived
	task automatic drain_status();
		s_tvalid <= 1'b0;
		while (status_due.size() != 0)
			@(negedge clk);
	endtask

	// APB write with junk above the register width
	task automatic write_reg(input ptcd_reg_t idx, input int unsigned val, input int width);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= (32'($urandom()) << width) | val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_reg(idx, pwdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all(input int hi_t, input int lo_t, input int hi_min, input int hi_max,
			input int lo_max, input int c_min, input int c_max, input int n_min);
		write_reg(REG_HIGH_TICKS, hi_t, 16);
		write_reg(REG_LOW_TICKS, lo_t, 16);
		write_reg(REG_HIGH_EDGES_MIN, hi_min, 16);
		write_reg(REG_HIGH_EDGES_MAX, hi_max, 16);
		write_reg(REG_LOW_EDGES_MAX, lo_max, 16);
		write_reg(REG_CLICKS_MIN, c_min, 4);
		write_reg(REG_CLICKS_MAX, c_max, 4);
		write_reg(REG_NOISE_EDGES, n_min, 16);
	endtask

	// Idle ticks under the reset configuration
	task automatic test_reset_defaults();
		repeat (3) send_tick(1'b0);
	endtask

	// Noise abort, then a short run through both windows that logs a call
	task automatic test_short_call();
		logic [13:0] ticks;
		ticks = 14'b10_1_11000_0_10000;
		drain_status();
		write_all(5, 1, 1, 3, 0, 1, 0, 1);
		for (int i = 13; i >= 0; i--)
			send_tick(ticks[i]);
	endtask

	// All registers at their top values, then mid-run at their bottom values but for the window lengths
	task automatic test_register_extremes();
		drain_status();
		write_all(65535, 65535, 65535, 65535, 65535, 15, 15, 65535);
		send_tick(1'b1);
		repeat (4) send_tick(1'($urandom_range(0, 1)));
		drain_status();
		write_all(5, 1, 0, 0, 0, 0, 0, 0);
		repeat (5) send_tick(1'($urandom_range(0, 1)));
	endtask

	// Mostly well-formed click trains under random settings and idling mixes
	task automatic test_random_traffic();
		int hi_t, lo_t, hi_min;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 72; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 72; end
				default: begin send_gap_pct = 22; stall_pct = 22; end
			endcase
			for (int k = 0; k < 2; k++) begin
				drain_status();
				hi_t   = $urandom_range(5, 10);
				lo_t   = $urandom_range(1, 6);
				hi_min = $urandom_range(0, hi_t);
				write_all(hi_t, lo_t, hi_min, $urandom_range(hi_min, hi_t + 1),
					$urandom_range(0, lo_t), $urandom_range(0, 4), $urandom_range(0, 4),
					$urandom_range(0, hi_t / 5 + 1));
				repeat (95) send_tick(next_edge());
			end
		end
	endtask

	// Status beat checker
	always @(posedge clk) begin
		ptcd_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = ptcd_result_t'(m_tdata[RESULT_W-1:0]);
			if (status_due.size() == 0) begin
				flag_mismatch("unexpected beat", 32'd0, got.calls_total);
			end else begin
				want = status_due.pop_front();
				if (got.active !== want.active)
					flag_mismatch("active", 32'(want.active), 32'(got.active));
				if (got.phase !== want.phase)
					flag_mismatch("phase", 32'(want.phase), 32'(got.phase));
				if (got.call_found !== want.call_found)
					flag_mismatch("call_found", 32'(want.call_found), 32'(got.call_found));
				if (got.calls_total !== want.calls_total)
					flag_mismatch("calls_total", want.calls_total, got.calls_total);
			end
		end
	end

	// Run limit
	initial begin
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		mismatches   = 0;
		send_gap_pct = 0;
		stall_pct    = 0;
		edge_goal    = 0;
		noisy_run    = 1'b0;
		// predicted state after reset
		cfg_hi_ticks  = HIGH_TICKS_RST;
		cfg_lo_ticks  = LOW_TICKS_RST;
		cfg_hi_min    = HIGH_EDGES_MIN_RST;
		cfg_hi_max    = HIGH_EDGES_MAX_RST;
		cfg_lo_max    = LOW_EDGES_MAX_RST;
		cfg_clk_min   = CLICKS_MIN_RST;
		cfg_clk_max   = CLICKS_MAX_RST;
		cfg_noise_min = NOISE_EDGES_RST;
		set_window(PHASE_CODE_IDLE);
		clicks      = '0;
		noise_armed = 1'b0;
		calls_seen  = '0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_short_call();
		test_register_extremes();
		test_random_traffic();

		// wait out the last beats, then idle on to catch strays
		s_tvalid <= 1'b0;
		for (int w = 0; w < 20000 && status_due.size() != 0; w++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		mismatches += status_due.size();

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ptcd_pkg.sv
hw/rtl/ptcd_cfg_regs.sv
hw/rtl/ptcd_fsm.sv
hw/rtl/ptcd_out_reg.sv
hw/rtl/pulse_train_call_detector_core.sv
hw/rtl/ptcd_checker.sv
bench/pulse_train_call_detector_core_tb.sv
